@@ hw/rtl/decimal_number_recognizer_top_defines.svh @@
// Assertion macros for the decimal number recognizer.
// Used by decimal_number_recognizer_top; no other dependencies.
`ifndef DECIMAL_NUMBER_RECOGNIZER_TOP_DEFINES_SVH
`define DECIMAL_NUMBER_RECOGNIZER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DNR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dnr assertion failed");
`define DNR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dnr assertion failed");
`else
`define DNR_ASSERT_SAME(label, clk, rst, ante, cons)
`define DNR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/dnr_pkg.sv @@
// Package for the decimal number recognizer: widths, character codes,
// phase type and the flag struct shared by the step logic and the top level.
package dnr_pkg;

   localparam int COUNT_WIDTH_DEF = 10;
   localparam int CODE_W          = 10;
   localparam int LIMIT_W         = 10;
   localparam int CH_W            = 8;

   localparam logic [CODE_W-1:0]  CODE_MAX    = 10'd1023;
   localparam logic [CODE_W-1:0]  CODE_NAN    = 10'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd200;

   // register index as seen in paddr[2]
   localparam logic LIMIT_REG_IDX = 1'b0;

   localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CH_W-1:0] CH_EXP_UC = 8'h45;
   localparam logic [CH_W-1:0] CH_EXP_LC = 8'h65;
   localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE   = 8'h39;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_INT   = 3'd1,
      PH_FRAC  = 3'd2,
      PH_EXP   = 3'd3,
      PH_EXPD  = 3'd4,
      PH_REJ   = 3'd5
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      int_seen;
   } flags_type;

   localparam flags_type FLAGS_CLEAR = '{phase: PH_START, int_seen: 1'b0};

endpackage

@@ hw/rtl/dnr_step.sv @@
// One-character step of the recognizer: next word state and end-of-word result.
// Purely combinational; depends on dnr_pkg.
module dnr_step
   import dnr_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  flags_type              flags_cur,
   input  logic [COUNT_WIDTH-1:0] tail_cur,
   input  logic [COUNT_WIDTH-1:0] chars_cur,
   input  logic [CH_W-1:0]        ch,
   input  logic                   last,
   input  logic                   empty_req,
   input  logic [LIMIT_W-1:0]     length_limit,
   output flags_type              flags_nx,
   output logic [COUNT_WIDTH-1:0] tail_nx,
   output logic [COUNT_WIDTH-1:0] chars_nx,
   output logic                   res_valid,
   output logic [CODE_W-1:0]      res_code
);

   localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
   localparam int SUM_W = (COUNT_WIDTH + 1 > CODE_W) ? COUNT_WIDTH + 1 : CODE_W;

   logic                   is_dig;
   logic                   is_exp;
   logic                   is_sign;
   logic                   any_dig;
   logic [COUNT_WIDTH-1:0] tail_inc;
   logic [COUNT_WIDTH-1:0] chars_inc;
   flags_type              flags_stp;
   logic [COUNT_WIDTH-1:0] tail_stp;
   logic [SUM_W-1:0]       code_sum;
   logic                   reject;
   logic [CODE_W-1:0]      word_code;

   assign is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_exp  = (ch == CH_EXP_UC) || (ch == CH_EXP_LC);
   assign is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign any_dig = flags_cur.int_seen || (tail_cur != '0);

   // saturating counters
   assign tail_inc  = (tail_cur == '1) ? tail_cur : COUNT_WIDTH'(tail_cur + 1'b1);
   assign chars_inc = (chars_cur == '1) ? chars_cur : COUNT_WIDTH'(chars_cur + 1'b1);

   always_comb begin
      flags_stp = flags_cur;
      tail_stp  = tail_cur;
      unique case (flags_cur.phase)
         PH_START: begin
            if (ch == CH_MINUS) begin
               flags_stp.phase = PH_INT;
            end else if (is_dig) begin
               flags_stp.phase    = PH_INT;
               flags_stp.int_seen = 1'b1;
            end else if (ch == CH_DOT) begin
               flags_stp.phase = PH_FRAC;
            end else begin
               flags_stp.phase = PH_REJ;
            end
         end
         PH_INT: begin
            if (is_dig) begin
               flags_stp.int_seen = 1'b1;
            end else if (ch == CH_DOT) begin
               flags_stp.phase = PH_FRAC;
            end else if (is_exp && any_dig) begin
               flags_stp.phase = PH_EXP;
            end else begin
               flags_stp.phase = PH_REJ;
            end
         end
         PH_FRAC: begin
            if (is_dig) begin
               tail_stp = tail_inc;
            end else if (is_exp && any_dig) begin
               flags_stp.phase = PH_EXP;
            end else begin
               flags_stp.phase = PH_REJ;
            end
         end
         PH_EXP: begin
            if (is_sign) begin
               flags_stp.phase = PH_EXPD;
            end else if (is_dig) begin
               tail_stp        = tail_inc;
               flags_stp.phase = PH_EXPD;
            end else begin
               flags_stp.phase = PH_REJ;
            end
         end
         PH_EXPD: begin
            if (is_dig) begin
               tail_stp = tail_inc;
            end else begin
               flags_stp.phase = PH_REJ;
            end
         end
         default: begin
            flags_stp.phase = PH_REJ;
         end
      endcase
   end

   assign reject = (CMP_W'(chars_inc) >= CMP_W'(length_limit)) ||
                   (flags_stp.phase == PH_REJ) ||
                   !(flags_stp.int_seen || (tail_stp != '0));
   assign code_sum = SUM_W'(tail_stp) + SUM_W'(1);

   always_comb begin
      if (reject) begin
         word_code = CODE_NAN;
      end else if (code_sum > SUM_W'(CODE_MAX)) begin
         word_code = CODE_MAX;
      end else begin
         word_code = CODE_W'(code_sum);
      end
   end

   always_comb begin
      flags_nx  = flags_stp;
      tail_nx   = tail_stp;
      chars_nx  = chars_inc;
      res_valid = 1'b0;
      res_code  = word_code;
      if (empty_req) begin
         // drop any word in progress
         flags_nx  = FLAGS_CLEAR;
         tail_nx   = '0;
         chars_nx  = '0;
         res_valid = 1'b1;
         res_code  = CODE_NAN;
      end else if (last) begin
         flags_nx  = FLAGS_CLEAR;
         tail_nx   = '0;
         chars_nx  = '0;
         res_valid = 1'b1;
      end
   end

endmodule

@@ hw/rtl/decimal_number_recognizer_top.sv @@
// Decimal number recognizer, top level: input register, step logic, result register.
// A word's result code is registered in the result register once its last character has passed the input register.
// Throughput: one character per cycle while the result register is not stalled; the word state updates per character.
// Reset (synchronous): clears word state and both valids, length_limit returns to 200.
// Depends on dnr_pkg, dnr_step and decimal_number_recognizer_top_defines.svh.
`include "decimal_number_recognizer_top_defines.svh"

module decimal_number_recognizer_top
   import dnr_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CH_W-1:0]    req_ch,
   input  logic               req_last,
   input  logic               req_empty_req,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CODE_W-1:0]  rsp_result_code,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [CH_W-1:0]        in_ch_ff;
   logic                   in_last_ff;
   logic                   in_empty_ff;
   flags_type              flags_ff;
   flags_type              flags_in;
   logic [COUNT_WIDTH-1:0] tail_ff;
   logic [COUNT_WIDTH-1:0] tail_in;
   logic [COUNT_WIDTH-1:0] chars_ff;
   logic [COUNT_WIDTH-1:0] chars_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [CODE_W-1:0]      rsp_code_ff;
   logic [LIMIT_W-1:0]     limit_ff;
   logic                   advance;
   logic                   load_in;
   logic                   step_valid;
   logic [CODE_W-1:0]      step_code;
   logic                   csr_write;

   // the step stage moves on whenever the result register is free or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign load_in   = !in_valid_ff || advance;
   assign req_stall = !load_in;

   assign in_valid_in = load_in ? req_valid : in_valid_ff;

   dnr_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .flags_cur    (flags_ff),
      .tail_cur     (tail_ff),
      .chars_cur    (chars_ff),
      .ch           (in_ch_ff),
      .last         (in_last_ff),
      .empty_req    (in_empty_ff),
      .length_limit (limit_ff),
      .flags_nx     (flags_in),
      .tail_nx      (tail_in),
      .chars_nx     (chars_in),
      .res_valid    (step_valid),
      .res_code     (step_code)
   );

   assign rsp_valid_in = advance ? (in_valid_ff && step_valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= FLAGS_CLEAR;
         tail_ff      <= '0;
         chars_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && in_valid_ff) begin
            flags_ff <= flags_in;
            tail_ff  <= tail_in;
            chars_ff <= chars_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load_in) begin
         in_ch_ff    <= req_ch;
         in_last_ff  <= req_last;
         in_empty_ff <= req_empty_req;
      end
      if (advance) begin
         rsp_code_ff <= step_code;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;

   // configuration port
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write && (paddr[2] == LIMIT_REG_IDX)) begin
         limit_ff <= pwdata[LIMIT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == LIMIT_REG_IDX) ? 32'(limit_ff) : '0;

   `DNR_ASSERT_SAME(a_stall_needs_word, clock, reset, req_stall, in_valid_ff)
   `DNR_ASSERT_NEXT(a_end_gives_result, clock, reset,
                    in_valid_ff && advance && (in_last_ff || in_empty_ff), rsp_valid_ff)
   `DNR_ASSERT_NEXT(a_end_clears_word, clock, reset,
                    in_valid_ff && advance && (in_last_ff || in_empty_ff),
                    (flags_ff.phase == PH_START) && (chars_ff == '0) && (tail_ff == '0))

endmodule

@@ bench/decimal_number_recognizer_top_tb.sv @@
// Testbench for decimal_number_recognizer_top: streams words one character at a time,
// predicts each result code in a scoreboard class and checks every returned word.
// Depends on dnr_pkg and the RTL of the recogniser only.
module decimal_number_recognizer_top_tb
   import dnr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int             QUIET_LIMIT = 4000;
   localparam int             DRAIN_WAIT  = 6;
   localparam int             STAGE_ITEMS = 60;
   localparam logic [2:0]     LIMIT_ADDR  = {LIMIT_REG_IDX, 2'b00};
   localparam logic [2:0]     UNUSED_ADDR = 3'd4;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   // Predicts the code of each finished word and holds the codes still due.
   class numeral_scoreboard_type;
      logic [LIMIT_W-1:0]         limit;
      phase_type                  ph;
      logic                       int_seen;
      logic [COUNT_WIDTH_DEF-1:0] tail;
      logic [COUNT_WIDTH_DEF-1:0] chars;
      logic [CODE_W-1:0]          due_codes[$];
      int                         errors;

      function new();
         limit  = LIMIT_RESET;
         errors = 0;
         clear_word();
      endfunction

      function void clear_word();
         ph       = PH_START;
         int_seen = 1'b0;
         tail     = '0;
         chars    = '0;
      endfunction

      function void write_reg(logic [2:0] addr, logic [31:0] data);
         if (addr[2] == LIMIT_REG_IDX) begin
            limit = data[LIMIT_W-1:0];
         end
      endfunction

      function int pending();
         return due_codes.size();
      endfunction

      function void note_char(logic [CH_W-1:0] ch, logic last, logic empty);
         logic             dig;
         logic             expm;
         logic             any_digit;
         logic [CODE_W:0]  code;
         if (empty) begin
            clear_word();
            due_codes.push_back(CODE_NAN);
            return;
         end
         if (chars != '1) begin
            chars++;
         end
         dig       = (ch >= CH_ZERO) && (ch <= CH_NINE);
         expm      = (ch == CH_EXP_UC) || (ch == CH_EXP_LC);
         any_digit = int_seen || (tail != 0);
         case (ph)
            PH_START: begin
               if (ch == CH_MINUS) begin
                  ph = PH_INT;
               end else if (dig) begin
                  int_seen = 1'b1;
                  ph = PH_INT;
               end else if (ch == CH_DOT) begin
                  ph = PH_FRAC;
               end else begin
                  ph = PH_REJ;
               end
            end
            PH_INT: begin
               if (dig) begin
                  int_seen = 1'b1;
               end else if (ch == CH_DOT) begin
                  ph = PH_FRAC;
               end else if (expm && any_digit) begin
                  ph = PH_EXP;
               end else begin
                  ph = PH_REJ;
               end
            end
            PH_FRAC: begin
               if (dig) begin
                  if (tail != '1) tail++;
               end else if (expm && any_digit) begin
                  ph = PH_EXP;
               end else begin
                  ph = PH_REJ;
               end
            end
            PH_EXP: begin
               if (ch == CH_PLUS || ch == CH_MINUS) begin
                  ph = PH_EXPD;
               end else if (dig) begin
                  if (tail != '1) tail++;
                  ph = PH_EXPD;
               end else begin
                  ph = PH_REJ;
               end
            end
            PH_EXPD: begin
               if (dig) begin
                  if (tail != '1) tail++;
               end else begin
                  ph = PH_REJ;
               end
            end
            default: ph = PH_REJ;
         endcase
         if (!last) return;
         if (chars >= limit || ph == PH_REJ || !(int_seen || tail != 0)) begin
            due_codes.push_back(CODE_NAN);
         end else begin
            code = {1'b0, tail} + 1'b1;
            due_codes.push_back(code > CODE_MAX ? CODE_MAX : code[CODE_W-1:0]);
         end
         clear_word();
      endfunction

      function void compare(string what, int expv, int actv);
         if (expv != actv) begin
            if (errors < 10) begin
               $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, expv, actv);
            end
            errors++;
         end
      endfunction

      function void check_code(logic [CODE_W-1:0] actual);
         if (due_codes.size() == 0) begin
            if (errors < 10) begin
               $display("%0t: result_code %0d with no word pending", $realtime, actual);
            end
            errors++;
         end else begin
            compare("result_code", due_codes.pop_front(), actual);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [CH_W-1:0]    req_ch;
   logic               req_last;
   logic               req_empty_req;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [CODE_W-1:0]  rsp_result_code;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   numeral_scoreboard_type sb;
   logic [CH_W-1:0]    word_buf[$];
   int                 items_sent     = 0;
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   int                 hold_off_left  = 0;
   int                 quiet_cycles   = 0;

   decimal_number_recognizer_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_last        (req_last),
      .req_empty_req   (req_empty_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_code (rsp_result_code),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: a long hold-off first when one is requested, else random stalls.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_stall <= 1'b1;
            hold_off_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_code(rsp_result_code);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [CH_W-1:0] rand_digit();
      return CH_ZERO + CH_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [CH_W-1:0] rand_symbol();
      case ($urandom_range(0, 6))
         0: return CH_MINUS;
         1: return CH_PLUS;
         2: return CH_DOT;
         3: return CH_EXP_UC;
         4: return CH_EXP_LC;
         5: return rand_digit();
         default: return CH_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly well-formed numbers with random parts; some damaged, some pure noise.
   function automatic void make_number_word();
      int kind;
      word_buf.delete();
      if ($urandom_range(0, 3) == 0) word_buf.push_back(CH_MINUS);
      repeat ($urandom_range(0, 4)) word_buf.push_back(rand_digit());
      if ($urandom_range(0, 1) == 1) begin
         word_buf.push_back(CH_DOT);
         repeat ($urandom_range(0, 5)) word_buf.push_back(rand_digit());
      end
      if ($urandom_range(0, 2) == 0) begin
         word_buf.push_back($urandom_range(0, 1) ? CH_EXP_UC : CH_EXP_LC);
         case ($urandom_range(0, 2))
            0: word_buf.push_back(CH_PLUS);
            1: word_buf.push_back(CH_MINUS);
            default: ;
         endcase
         repeat ($urandom_range(0, 3)) word_buf.push_back(rand_digit());
      end
      if (word_buf.size() == 0) word_buf.push_back(rand_symbol());
      kind = $urandom_range(0, 9);
      if (kind == 7) begin
         word_buf[$urandom_range(0, word_buf.size() - 1)] = CH_W'($urandom_range(0, 255));
      end else if (kind == 8) begin
         word_buf.insert($urandom_range(0, word_buf.size() - 1), rand_symbol());
      end else if (kind == 9) begin
         word_buf.delete();
         repeat ($urandom_range(1, 6)) word_buf.push_back(rand_symbol());
      end
   endfunction

   task automatic send_char(input logic [CH_W-1:0] ch, input logic last, input logic empty);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_ch        <= ch;
      req_last      <= last;
      req_empty_req <= empty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_char(ch, last, empty);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_word_buf();
      for (int i = 0; i < word_buf.size(); i++) begin
         send_char(word_buf[i], i == word_buf.size() - 1, 1'b0);
      end
   endtask

   task automatic send_text(input string s);
      word_buf.delete();
      for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
      send_word_buf();
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                             output logic [31:0] rd);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      if (wr) sb.write_reg(addr, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid and wait until every word has come back and the pipe is empty.
   task automatic drain_words();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic configure(input int stage);
      logic [31:0] data;
      logic [31:0] rd;
      data = $urandom;
      case (stage)
         1: data[LIMIT_W-1:0] = LIMIT_W'(1);
         2: data[LIMIT_W-1:0] = LIMIT_W'(4);
         3: data[LIMIT_W-1:0] = LIMIT_W'($urandom_range(2, 12));
         4: data[LIMIT_W-1:0] = LIMIT_W'(1023);
         5: data[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 1023));
         6: data[LIMIT_W-1:0] = LIMIT_W'(7);
         default: data[LIMIT_W-1:0] = LIMIT_RESET;
      endcase
      csr_access(1'b1, LIMIT_ADDR, data, rd);
      // writes to the unused slot must leave the limit alone
      if (stage == 2) csr_access(1'b1, UNUSED_ADDR, $urandom, rd);
      csr_access(1'b0, LIMIT_ADDR, 32'd0, rd);
      sb.compare("length_limit", sb.limit, rd[LIMIT_W-1:0]);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_SEND: begin send_idle_pct = 79; recv_stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 79; end
         IDLE_BOTH: begin send_idle_pct = 20; recv_stall_pct = 20; end
         default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   task automatic run_directed();
      send_text("0");
      send_text("-");
      send_text(".");
      send_text(".5");
      send_text("1e");
      send_text("2E+");
      send_text("-.5e-3");
      send_text("e5");
      send_text(":");
      send_char(8'hFF, 1'b1, 1'b0);
      send_char(8'h00, 1'b1, 1'b0);
      // abandon a word half way, then an empty word marked last
      send_char(CH_ZERO + 8'd1, 1'b0, 1'b0);
      send_char(CH_ZERO + 8'd2, 1'b0, 1'b0);
      send_char(8'hA5, 1'b0, 1'b1);
      send_char(8'h5A, 1'b1, 1'b1);
   endtask

   task automatic run_random(input int count);
      int goal;
      int pick;
      int cut;
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 14);
         if (pick == 0) begin
            send_char(CH_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         end else begin
            make_number_word();
            if (pick == 1) begin
               cut = $urandom_range(0, word_buf.size() - 1);
               for (int i = 0; i < cut; i++) send_char(word_buf[i], 1'b0, 1'b0);
               send_char(CH_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
               send_word_buf();
            end
         end
      end
   endtask

   task automatic run_pressure_and_long();
      // hold the receiver off and offer forty one-digit words so that the block backs up
      hold_off_left = 300;
      repeat (40) send_char(rand_digit(), 1'b1, 1'b0);
      // a long fraction: accepted with a large digit count
      word_buf.delete();
      word_buf.push_back(CH_ZERO);
      word_buf.push_back(CH_DOT);
      repeat (100) word_buf.push_back(rand_digit());
      send_word_buf();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_ch        = '0;
      req_last      = 1'b0;
      req_empty_req = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      sb            = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int stage = 0; stage < 8; stage++) begin
         set_idling(idle_mode_type'(stage % 4));
         if (stage > 0) configure(stage);
         if (stage == 0) run_directed();
         if (stage == 4) run_pressure_and_long();
         run_random(STAGE_ITEMS);
         drain_words();
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
